// ===== src/lpbg_pkg.sv =====
package lpbg_pkg;

	localparam int unsigned STATE_W = 31;
	localparam int unsigned RESULT_W = 32;
	localparam int unsigned COUNT_W = 6;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned MUL_W = 15;
	localparam int unsigned PROD_W = STATE_W + MUL_W;

	localparam logic [STATE_W:0] LEHMER_MOD = 32'h7FFF_FFFF;
	localparam logic [MUL_W-1:0] LEHMER_MUL = 15'd16807;
	localparam logic [COUNT_W-1:0] MAX_BITS = 6'd32;
	localparam logic [STATE_W-1:0] SEED_RESET = 31'd1;

	// Register index decoded from paddr[2].
	localparam logic REG_SEED = 1'b0;

	localparam logic ACT_VALUE = 1'b0;
	localparam logic ACT_BITS = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} seq_state_t;

	typedef struct packed {
		logic                wr;
		logic [STATE_W-1:0] value;
	} seed_wr_t;

endpackage

// ===== src/lpbg_if.sv =====
interface lpbg_req_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [lpbg_pkg::COUNT_W-1:0] bit_count;

	modport source (output valid, output action, output bit_count, input ready);
	modport sink (input valid, input action, input bit_count, output ready);
endinterface

interface lpbg_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [lpbg_pkg::RESULT_W-1:0] result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

// ===== src/lpbg_step.sv =====
module lpbg_step (
	input  logic [lpbg_pkg::STATE_W-1:0] x,
	output logic [lpbg_pkg::STATE_W-1:0] y
);
	import lpbg_pkg::*;

	logic [PROD_W-1:0]  prod;
	logic [STATE_W:0]   fold;
	logic [STATE_W:0]   fold_sub;

	// 2^31 is congruent to 1, so the high part of the product adds onto the low part.
	// The folded sum stays below twice the modulus, so one subtraction finishes it.
	always_comb begin
		prod = PROD_W'(x) * PROD_W'(LEHMER_MUL);
		fold = {1'b0, prod[STATE_W-1:0]} + (STATE_W+1)'(prod[PROD_W-1:STATE_W]);
		fold_sub = fold - LEHMER_MOD;
		y = (fold >= LEHMER_MOD) ? fold_sub[STATE_W-1:0] : fold[STATE_W-1:0];
	end
endmodule

// ===== src/lpbg_apb.sv =====
module lpbg_apb (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lpbg_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lpbg_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lpbg_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output lpbg_pkg::seed_wr_t              seed_wr
);
	import lpbg_pkg::*;

	logic [STATE_W-1:0] seed_q;
	logic                wr_seed;

	assign pready = 1'b1;
	assign wr_seed = psel && penable && pwrite && (paddr[2] == REG_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (wr_seed) begin
			seed_q <= pwdata[STATE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_SEED) begin
			prdata = {{(APB_DATA_W-STATE_W){1'b0}}, seed_q};
		end
		seed_wr.wr = wr_seed;
		seed_wr.value = pwdata[STATE_W-1:0];
	end
endmodule

// ===== src/lehmer_prng_bit_gather.sv =====
// A value transaction returns the next generator state. A bits transaction with count n
// (n saturated at 32) gathers bit 0 of n successive states, and a count of zero returns 0.
// A new request is taken only in the idle state, once the previous result is in the output register.
// The single generator step unit (constant multiply and modular fold) runs once per cycle in the run state.
// A new request is taken while a finished result still waits in the output register.
// Reset (arst_n, asynchronous): seed and generator state return to 1, the sequencer idles.
module lehmer_prng_bit_gather (
	input  logic                            clk,
	input  logic                            arst_n,
	lpbg_req_if.sink                        req,
	lpbg_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lpbg_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lpbg_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lpbg_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import lpbg_pkg::*;

	seq_state_t          state_q;
	seq_state_t          state_nxt;
	seed_wr_t            seed_wr;
	logic [STATE_W-1:0]  gen_state_q;
	logic [STATE_W-1:0]  step_y;
	logic [COUNT_W-1:0]  cnt_q;
	logic [COUNT_W-1:0]  cnt_init;
	logic                act_q;
	logic [RESULT_W-1:0] acc_q;
	logic [RESULT_W-1:0] acc_nxt;
	logic                rsp_valid_q;
	logic [RESULT_W-1:0] rsp_result_q;
	logic                accept;
	logic                last_step;
	logic                out_free;
	logic                load_out;
	logic                zero_count;

	lpbg_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.seed_wr (seed_wr)
	);

	lpbg_step u_step (
		.x (gen_state_q),
		.y (step_y)
	);

	assign accept = req.valid && req.ready;
	assign last_step = (state_q == ST_RUN) && (cnt_q == COUNT_W'(1));
	assign out_free = !rsp_valid_q || rsp.ready;
	assign zero_count = (req.action == ACT_BITS) && (req.bit_count == '0);
	assign rsp.valid = rsp_valid_q;
	assign rsp.result = rsp_result_q;

	always_comb begin
		cnt_init = COUNT_W'(1);
		if (req.action == ACT_BITS) begin
			cnt_init = (req.bit_count > MAX_BITS) ? MAX_BITS : req.bit_count;
		end
		if (act_q == ACT_BITS) begin
			acc_nxt = {acc_q[RESULT_W-2:0], step_y[0]};
		end else begin
			acc_nxt = {{(RESULT_W-STATE_W){1'b0}}, step_y};
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = zero_count ? ST_WAIT : ST_RUN;
				end
			end
			ST_RUN: begin
				if (last_step) begin
					state_nxt = out_free ? ST_IDLE : ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_RUN:  load_out = last_step && out_free;
			ST_WAIT: load_out = out_free;
			default: begin
				req.ready = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gen_state_q <= SEED_RESET;
			rsp_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (seed_wr.wr) begin
				gen_state_q <= seed_wr.value;
			end else if (state_q == ST_RUN) begin
				gen_state_q <= step_y;
			end
			if (accept) begin
				cnt_q <= cnt_init;
			end else if (state_q == ST_RUN) begin
				cnt_q <= cnt_q - COUNT_W'(1);
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= req.action;
			acc_q <= '0;
		end else if (state_q == ST_RUN) begin
			acc_q <= acc_nxt;
		end
		if (load_out) begin
			rsp_result_q <= (state_q == ST_RUN) ? acc_nxt : acc_q;
		end
	end

	a_run_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> cnt_q != '0)
		else $error("step counter empty while running");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("sequencer stayed idle after taking a request");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("result loaded over a pending transaction");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_RUN || $past(state_q) == ST_WAIT)
		else $error("result appeared without work in flight");
endmodule

// ===== verif/lehmer_prng_bit_gather_test.sv =====
`timescale 1ns / 1ps

module lehmer_prng_bit_gather_test;
	import lpbg_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned RANDOM_PHASES = 5;
	localparam int unsigned PHASE_ITEMS = 226;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam logic [APB_ADDR_W-1:0] ADDR_SEED = {REG_SEED, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = {~REG_SEED, 2'b00};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	lpbg_req_if req_if();
	lpbg_rsp_if rsp_if();

	lehmer_prng_bit_gather dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Shadow copy of the generator and its seed register.
	logic [STATE_W-1:0] model_seed;
	logic [STATE_W-1:0] model_state;
	logic [RESULT_W-1:0] expected_results[$];
	logic [RESULT_W-1:0] oldest_result;

	int unsigned mismatches;
	int unsigned value_reqs;
	int unsigned bits_reqs;
	int unsigned seed_writes;
	int unsigned results_seen;
	int unsigned quiet_cycles;
	bit src_idle_en;
	bit snk_idle_en;
	bit hold_req;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [STATE_W-1:0] lehmer_advance(input logic [STATE_W-1:0] x);
		logic [63:0] prod;
		prod = 64'(x) * 64'(LEHMER_MUL);
		return STATE_W'(prod % 64'(LEHMER_MOD));
	endfunction

	// Advances the shadow generator for one request and returns the word it yields.
	function automatic logic [RESULT_W-1:0] gather_result(input logic act,
			input logic [COUNT_W-1:0] cnt);
		logic [RESULT_W-1:0] acc;
		int unsigned steps;
		acc = '0;
		if (act == ACT_VALUE) begin
			model_state = lehmer_advance(model_state);
			acc = RESULT_W'(model_state);
		end else begin
			steps = (cnt > MAX_BITS) ? 32'(MAX_BITS) : 32'(cnt);
			for (int unsigned i = 0; i < steps; i++) begin
				model_state = lehmer_advance(model_state);
				acc = {acc[RESULT_W-2:0], model_state[0]};
			end
		end
		return acc;
	endfunction

	function automatic void report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("mismatch on %s: expected %h, got %h", what, want, got);
		end
	endfunction

	task automatic send_request(input logic act, input logic [COUNT_W-1:0] cnt);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.action <= act;
		req_if.bit_count <= cnt;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		expected_results.push_back(gather_result(act, cnt));
		if (act == ACT_VALUE) begin
			value_reqs++;
		end else begin
			bits_reqs++;
		end
	endtask

	// Stops offering requests and lets every outstanding transaction come back.
	task automatic drain_results();
		req_if.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr[2] == REG_SEED) begin
			model_seed = data[STATE_W-1:0];
			model_state = model_seed;
		end
		seed_writes++;
		@(posedge clk);
	endtask

	task automatic check_seed_readback();
		logic [APB_DATA_W-1:0] data;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_SEED;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (data !== APB_DATA_W'(model_seed)) begin
			report_mismatch("seed readback", APB_DATA_W'(model_seed), data);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing outstanding", '0, rsp_if.result);
			end else begin
				oldest_result = expected_results.pop_front();
				if (rsp_if.result !== oldest_result) begin
					report_mismatch("result", oldest_result, rsp_if.result);
				end
			end
		end
	end

	initial begin : response_sink
		int unsigned held;
		rsp_if.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				rsp_if.ready <= 1'b0;
				held = 0;
				while (held < HOLD_CYCLES) begin
					@(posedge clk);
					held++;
				end
				hold_req = 1'b0;
				rsp_if.ready <= 1'b1;
			end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (req_if.valid && req_if.ready) ||
				(rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", quiet_cycles);
			$display("[lehmer_prng_bit_gather] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Out of reset the seed is 1, so the first value is the multiplier itself.
	task automatic test_reset_state();
		check_seed_readback();
		repeat (3) send_request(ACT_VALUE, '0);
		drain_results();
	endtask

	task automatic test_modes_and_counts();
		send_request(ACT_VALUE, 6'd63);
		send_request(ACT_BITS, 6'd0);
		send_request(ACT_BITS, 6'd1);
		send_request(ACT_BITS, 6'd2);
		send_request(ACT_BITS, 6'd31);
		send_request(ACT_BITS, 6'd32);
		send_request(ACT_BITS, 6'd33);
		send_request(ACT_BITS, 6'd63);
		send_request(ACT_BITS, 6'h15);
		send_request(ACT_BITS, 6'h2A);
		drain_results();
	endtask

	task automatic test_seed_extremes();
		write_reg(ADDR_SEED, 32'h7FFF_FFFE);
		check_seed_readback();
		send_request(ACT_VALUE, '0);
		send_request(ACT_BITS, 6'd32);
		drain_results();
		// An all-ones seed equals the modulus and collapses to zero on the next step.
		write_reg(ADDR_SEED, 32'hFFFF_FFFF);
		check_seed_readback();
		send_request(ACT_VALUE, '0);
		send_request(ACT_BITS, 6'd5);
		drain_results();
		write_reg(ADDR_SEED, 32'h0000_0000);
		send_request(ACT_VALUE, '0);
		send_request(ACT_BITS, 6'd32);
		drain_results();
		// A write to the unused address must neither move the seed nor reload the state.
		write_reg(ADDR_SEED, 32'd12345);
		send_request(ACT_VALUE, '0);
		drain_results();
		write_reg(ADDR_SPARE, $urandom);
		check_seed_readback();
		send_request(ACT_VALUE, '0);
		send_request(ACT_BITS, 6'd7);
		drain_results();
	endtask

	// The receiver stops for a long stretch while requests keep coming, so the block
	// fills its output register and has to push back on its input.
	task automatic test_output_stall();
		write_reg(ADDR_SEED, $urandom_range(1, 32'h7FFF_FFFE));
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		hold_req = 1'b1;
		for (int n = 0; n < 8; n++) begin
			send_request(ACT_BITS, COUNT_W'($urandom_range(0, 6)));
		end
		drain_results();
	endtask

	task automatic test_random_traffic();
		logic [APB_DATA_W-1:0] seed_word;
		int unsigned kind;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			src_idle_en = (phase != RANDOM_PHASES - 1);
			snk_idle_en = (phase != RANDOM_PHASES - 1);
			case (phase)
				0: seed_word = 32'd1;
				1: seed_word = 32'h7FFF_FFFE;
				default: begin
					seed_word = $urandom_range(1, 32'h7FFF_FFFE);
					seed_word[31] = 1'($urandom_range(0, 1));
				end
			endcase
			write_reg(ADDR_SEED, seed_word);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				kind = $urandom_range(0, 9);
				if (kind < 3) begin
					send_request(ACT_VALUE, COUNT_W'($urandom));
				end else if (kind < 7) begin
					send_request(ACT_BITS, COUNT_W'($urandom_range(0, 32)));
				end else if (kind < 8) begin
					send_request(ACT_BITS, COUNT_W'($urandom_range(33, 63)));
				end else begin
					send_request(ACT_BITS, COUNT_W'($urandom_range(0, 4)));
				end
				if (src_idle_en && $urandom_range(0, 99) == 0) begin
					drain_results();
				end
			end
			drain_results();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_if.valid <= 1'b0;
		req_if.action <= ACT_VALUE;
		req_if.bit_count <= '0;
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		hold_req = 1'b0;
		model_seed = SEED_RESET;
		model_state = SEED_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_modes_and_counts();
		test_seed_extremes();
		test_output_stall();
		test_random_traffic();

		if (expected_results.size() != 0) begin
			report_mismatch("results never returned", expected_results.size(), 0);
		end
		$display("run covered %0d value and %0d bit-gather requests, %0d register writes",
			value_reqs, bits_reqs, seed_writes);
		$display("%0d results checked, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0) begin
			$display("[lehmer_prng_bit_gather] OK");
		end else begin
			$display("[lehmer_prng_bit_gather] ERROR");
		end
		$finish;
	end

endmodule

// ===== lehmer_prng_bit_gather.f =====
src/lpbg_pkg.sv
src/lpbg_if.sv
src/lpbg_step.sv
src/lpbg_apb.sv
src/lehmer_prng_bit_gather.sv
verif/lehmer_prng_bit_gather_test.sv
